@@ src/msu_pkg.sv @@
// Package for the merge sorter: the queue entry passed from the front end
// to the sort engine, queue sizing and the engine state encoding. No dependencies.
`default_nettype none

package msu_pkg;

    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 4;

    // One classified input item, as queued between the front end and the engine
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;  // final item of the sequence
        logic                      keep;  // item fits in the store
        logic                      ovf;   // on the final item: sequence lost items
    } entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_RUN,
        ST_MRD,
        ST_MWR,
        ST_ERD,
        ST_EOUT
    } back_state_t;

endpackage

`default_nettype wire

@@ src/msu_front.sv @@
// Front end of the merge sorter: accepts input items, decides store or drop
// and tracks overflow per sequence. Depends on msu_pkg.
`default_nettype none

module msu_front #(
    parameter int CAPACITY = 64
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire signed [31:0]          value,
    input  wire                        last_in,
    input  wire                        q_full,
    output logic                       q_push,
    output msu_pkg::entry_t            q_entry
);
    import msu_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             keep;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign keep     = count_reg < CNT_W'(CAPACITY);

    always_comb
    begin
        q_entry.value = value;
        q_entry.last  = last_in;
        q_entry.keep  = keep;
        q_entry.ovf   = dropped_reg || !keep;
    end

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (q_push)
        begin
            if (last_in)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                count_next   = count_reg + CNT_W'(keep);
                dropped_next = dropped_reg || !keep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

`default_nettype wire

@@ src/msu_fifo.sv @@
// Short queue of classified items between the front end and the sort engine.
// Depends on msu_pkg.
`default_nettype none

module msu_fifo (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  msu_pkg::entry_t    push_entry,
    output logic               full,
    input  wire                pop,
    output logic               not_empty,
    output msu_pkg::entry_t    head
);
    import msu_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full      = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign head      = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fill_reg <= fill_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

@@ src/msu_back.sv @@
// Sort engine: loads queued items into the element store, runs bottom-up merge
// passes between the store and a scratch memory, then emits results. Depends on msu_pkg.
`default_nettype none

module msu_back #(
    parameter int CAPACITY = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_not_empty,
    input  msu_pkg::entry_t     q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic signed [31:0]  sorted_value,
    output logic                last_out,
    output logic                overflow
);
    import msu_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int EXT_W  = CNT_W + 2;

    back_state_t state_reg, state_next;

    logic signed [VALUE_W-1:0] mem_a [CAPACITY];
    logic signed [VALUE_W-1:0] mem_b [CAPACITY];
    logic signed [VALUE_W-1:0] rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;
    logic signed [VALUE_W-1:0] src0, src1, wr_data;
    logic [ADDR_W-1:0]         rd_addr0, rd_addr1, wr_addr;
    logic                      we_a, we_b;

    logic [EXT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] lo_reg, lo_next, mid_reg, mid_next, hi_reg, hi_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             ovf_reg, ovf_next, sel_reg, sel_next;

    logic [EXT_W-1:0] mid_ext, hi_ext, width_dbl;
    logic [CNT_W-1:0] k_inc;
    logic             take_i, out_free, out_load, out_last;

    logic signed [VALUE_W-1:0] sorted_value_reg;
    logic                      out_valid_reg, last_out_reg, overflow_reg;

    // sel_reg low: current data lives in mem_a
    assign src0      = sel_reg ? rd_b0_reg : rd_a0_reg;
    assign src1      = sel_reg ? rd_b1_reg : rd_a1_reg;
    assign rd_addr0  = (state_reg == ST_ERD || state_reg == ST_EOUT) ?
                       k_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign rd_addr1  = j_reg[ADDR_W-1:0];
    assign wr_addr   = k_reg[ADDR_W-1:0];
    assign k_inc     = k_reg + CNT_W'(1);
    assign mid_ext   = EXT_W'(lo_reg) + width_reg;
    assign hi_ext    = EXT_W'(lo_reg) + (width_reg << 1);
    assign width_dbl = width_reg << 1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign take_i    = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || (src0 <= src1));
    assign out_last  = k_inc == n_reg;

    // Memories: one write port each, two registered read ports each
    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a[wr_addr] <= wr_data;
        if (we_b)
            mem_b[wr_addr] <= wr_data;
        rd_a0_reg <= mem_a[rd_addr0];
        rd_a1_reg <= mem_a[rd_addr1];
        rd_b0_reg <= mem_b[rd_addr0];
        rd_b1_reg <= mem_b[rd_addr1];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (q_not_empty && q_head.last)
                    state_next = ST_INIT;
            ST_INIT:
                state_next = (n_reg <= CNT_W'(1)) ? ST_ERD : ST_RUN;
            ST_RUN:
                state_next = ST_MRD;
            ST_MRD:
                state_next = ST_MWR;
            ST_MWR:
                if (k_inc == hi_reg)
                begin
                    if (hi_reg == n_reg && width_dbl >= EXT_W'(n_reg))
                        state_next = ST_ERD;
                    else
                        state_next = ST_RUN;
                end
                else
                    state_next = ST_MRD;
            ST_ERD:
                state_next = ST_EOUT;
            ST_EOUT:
                if (out_free)
                    state_next = out_last ? ST_LOAD : ST_ERD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Datapath control
    always_comb
    begin
        q_pop      = 1'b0;
        we_a       = 1'b0;
        we_b       = 1'b0;
        wr_data    = q_head.value;
        out_load   = 1'b0;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_LOAD:
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.keep)
                    begin
                        we_a   = 1'b1;
                        k_next = k_inc;
                    end
                    if (q_head.last)
                    begin
                        n_next   = k_reg + CNT_W'(q_head.keep);
                        ovf_next = q_head.ovf;
                    end
                end
            ST_INIT:
            begin
                width_next = EXT_W'(1);
                lo_next    = '0;
                k_next     = '0;
                sel_next   = 1'b0;
            end
            ST_RUN:
            begin
                mid_next = (mid_ext > EXT_W'(n_reg)) ? n_reg : mid_ext[CNT_W-1:0];
                hi_next  = (hi_ext > EXT_W'(n_reg)) ? n_reg : hi_ext[CNT_W-1:0];
                i_next   = lo_reg;
                j_next   = (mid_ext > EXT_W'(n_reg)) ? n_reg : mid_ext[CNT_W-1:0];
                k_next   = lo_reg;
            end
            ST_MRD:
            begin
            end
            ST_MWR:
            begin
                wr_data = take_i ? src0 : src1;
                we_a    = sel_reg;
                we_b    = !sel_reg;
                if (take_i)
                    i_next = i_reg + CNT_W'(1);
                else
                    j_next = j_reg + CNT_W'(1);
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    lo_next = hi_reg;
                    if (hi_reg == n_reg)
                    begin
                        // pass done: flip memories, double the run length
                        sel_next   = !sel_reg;
                        width_next = width_dbl;
                        lo_next    = '0;
                        if (width_dbl >= EXT_W'(n_reg))
                            k_next = '0;
                    end
                end
            end
            ST_ERD:
            begin
            end
            ST_EOUT:
                if (out_free)
                begin
                    out_load = 1'b1;
                    k_next   = out_last ? '0 : k_inc;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        n_reg     <= n_next;
        ovf_reg   <= ovf_next;
        sel_reg   <= sel_next;
        if (out_load)
        begin
            sorted_value_reg <= src0;
            last_out_reg     <= out_last;
            overflow_reg     <= ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign last_out     = last_out_reg;
    assign overflow     = overflow_reg;

endmodule

`default_nettype wire

@@ src/merge_sorter_unit.sv @@
// Top level of the merge sorter: front end, item queue and sort engine.
// Depends on msu_pkg, msu_front, msu_fifo and msu_back.
//
// Usage:
//   Input channel (in_valid / in_stall, value, last_in) carries one signed
//   value per item; last_in closes a sequence. Up to CAPACITY values are kept,
//   further ones are dropped and every result of that sequence has overflow set.
//   Output channel (out_valid / out_stall, sorted_value, last_out, overflow)
//   returns the kept values in ascending order, last_out on the final one.
// Timing:
//   Loading takes one item per cycle from a four-entry queue, when not empty.
//   Sorting runs ceil(log2(n)) merge passes; a pass takes each element through
//   a read state and a write state, plus a setup state per merge, as the merge
//   memories are read through registers. Emission takes each result through
//   a read state and an output state that waits on out_stall. While a sequence
//   sorts or drains, the queue keeps taking items of the next one until it fills.
// Reset:
//   rst_n clears the front-end counters, queue, engine state and output valid;
//   store contents are kept. A stalled result holds on the output register.
`default_nettype none

module merge_sorter_unit #(
    parameter int CAPACITY = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire signed [31:0]  value,
    input  wire                last_in,
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [31:0] sorted_value,
    output logic               last_out,
    output logic               overflow
);
    import msu_pkg::*;

    entry_t q_entry, q_head;
    logic   q_push, q_full, q_pop, q_not_empty;

    // Classify each item: store or drop, and carry the overflow mark
    msu_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .last_in  (last_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // Decouple intake from the sort engine
    msu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Load, merge passes, emit
    msu_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire
